FILE: rtl/nectx_pkg.sv
`timescale 1ns / 1ps

package nectx_pkg;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_LEAD_BURST = 3'd1,
        PH_LEAD_SPACE = 3'd2,
        PH_BIT_BURST  = 3'd3,
        PH_BIT_SPACE  = 3'd4,
        PH_STOP_BURST = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        CS_IDLE = 2'd0,
        CS_HIGH = 2'd1,
        CS_LOW1 = 2'd2,
        CS_LOW2 = 2'd3
    } carrier_step_t;

    localparam logic [2:0] REG_LEADER_PULSE_COUNT = 3'd0;
    localparam logic [2:0] REG_BIT_PULSE_COUNT    = 3'd1;
    localparam logic [2:0] REG_LEADER_SPACE_TICKS = 3'd2;
    localparam logic [2:0] REG_ONE_SPACE_TICKS    = 3'd3;
    localparam logic [2:0] REG_ZERO_SPACE_TICKS   = 3'd4;

    localparam logic [9:0]  LEADER_PULSE_RESET = 10'd342;
    localparam logic [9:0]  BIT_PULSE_RESET    = 10'd22;
    localparam logic [15:0] LEADER_SPACE_RESET = 16'd513;
    localparam logic [15:0] ONE_SPACE_RESET    = 16'd190;
    localparam logic [15:0] ZERO_SPACE_RESET   = 16'd62;

    typedef struct packed {
        logic       cmd;
        logic [7:0] address;
        logic [7:0] command;
    } item_t;

    typedef struct packed {
        logic ir_level;
        logic busy_res;
        logic accepted;
        logic frame_done;
    } result_t;

endpackage

FILE: rtl/nec_ir_frame_transmitter_top.sv
`timescale 1ns / 1ps

// NEC infrared frame transmitter driven by tick transactions. A transaction with cmd set
// starts a frame (address, inverted address, command, inverted command, LSB first) when
// the block is idle and is refused with accepted low while a frame is in flight; a
// transaction with cmd clear is one tick at three times the carrier rate and steps the
// emitter by one carrier sub-phase in a burst or one space tick in a space. A frame is a
// leader burst, the leader space, FRAME_BITS data bits (bit burst plus a one or zero space)
// and a trailing stop burst; a burst of N pulses takes 1 + 3N ticks, with N of zero as one.
// Every transaction yields exactly one result, registered in the cycle after it is taken;
// the next state is computed combinationally and registered with the result, so one
// transaction is accepted per clock while the result side keeps up. The cfg port, always
// ready, writes the registers; a count is loaded when its burst or space begins.
module nec_ir_frame_transmitter_top
    import nectx_pkg::*;
#(
    parameter int FRAME_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,

    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int BW = $clog2(FRAME_BITS + 1);

    logic [9:0]  leader_pulse_reg;
    logic [9:0]  bit_pulse_reg;
    logic [15:0] leader_space_reg;
    logic [15:0] one_space_reg;
    logic [15:0] zero_space_reg;

    phase_t                phase_reg, phase_next;
    carrier_step_t         carrier_reg, carrier_next;
    logic [9:0]            pulses_reg, pulses_next;
    logic [15:0]           space_reg, space_next;
    logic [FRAME_BITS-1:0] frame_reg, frame_next;
    logic [BW-1:0]         bits_reg, bits_next;

    result_t result_reg, result_next;
    logic    result_valid_reg;

    logic          item_fire;
    logic          acc;
    logic          done;
    carrier_step_t burst_carrier;
    logic [9:0]    burst_pulses;
    logic          burst_end;
    logic          space_end;
    logic [15:0]   space_dec;
    logic [BW-1:0] bits_inc;
    logic [31:0]   frame_word;

    assign cfg_ready    = 1'b1;
    assign item_stall   = result_valid_reg && result_stall;
    assign item_fire    = item_valid && !item_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign frame_word = {~item.command, item.command, ~item.address, item.address};
    assign bits_inc   = bits_reg + BW'(1);
    assign space_end  = (space_reg <= 16'd1);
    assign space_dec  = space_end ? 16'd0 : space_reg - 16'd1;

    // one carrier sub-phase
    always_comb
    begin
        burst_carrier = carrier_reg;
        burst_pulses  = pulses_reg;
        burst_end     = 1'b0;
        case (carrier_reg)
            CS_IDLE:
            begin
                burst_carrier = CS_HIGH;
            end
            CS_HIGH:
            begin
                if (pulses_reg != 10'd0)
                begin
                    burst_pulses = pulses_reg - 10'd1;
                end
                burst_carrier = CS_LOW1;
            end
            CS_LOW1:
            begin
                burst_carrier = CS_LOW2;
            end
            default:
            begin
                if (pulses_reg != 10'd0)
                begin
                    burst_carrier = CS_HIGH;
                end
                else
                begin
                    burst_carrier = CS_IDLE;
                    burst_end     = 1'b1;
                end
            end
        endcase
    end

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        carrier_next = carrier_reg;
        pulses_next  = pulses_reg;
        space_next   = space_reg;
        frame_next   = frame_reg;
        bits_next    = bits_reg;
        acc          = 1'b0;
        done         = 1'b0;
        if (item.cmd)
        begin
            if (phase_reg == PH_IDLE)
            begin
                frame_next   = frame_word[FRAME_BITS-1:0];
                bits_next    = '0;
                space_next   = 16'd0;
                phase_next   = PH_LEAD_BURST;
                carrier_next = CS_IDLE;
                pulses_next  = leader_pulse_reg;
                acc          = 1'b1;
            end
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_LEAD_BURST:
                begin
                    carrier_next = burst_carrier;
                    pulses_next  = burst_pulses;
                    if (burst_end)
                    begin
                        phase_next = PH_LEAD_SPACE;
                        space_next = leader_space_reg;
                    end
                end
                PH_LEAD_SPACE:
                begin
                    space_next = space_dec;
                    if (space_end)
                    begin
                        phase_next   = PH_BIT_BURST;
                        carrier_next = CS_IDLE;
                        pulses_next  = bit_pulse_reg;
                    end
                end
                PH_BIT_BURST:
                begin
                    carrier_next = burst_carrier;
                    pulses_next  = burst_pulses;
                    if (burst_end)
                    begin
                        phase_next = PH_BIT_SPACE;
                        space_next = frame_reg[0] ? one_space_reg : zero_space_reg;
                    end
                end
                PH_BIT_SPACE:
                begin
                    space_next = space_dec;
                    if (space_end)
                    begin
                        frame_next   = frame_reg >> 1;
                        bits_next    = bits_inc;
                        carrier_next = CS_IDLE;
                        pulses_next  = bit_pulse_reg;
                        if (bits_inc >= BW'(FRAME_BITS))
                        begin
                            phase_next = PH_STOP_BURST;
                        end
                        else
                        begin
                            phase_next = PH_BIT_BURST;
                        end
                    end
                end
                PH_STOP_BURST:
                begin
                    carrier_next = burst_carrier;
                    pulses_next  = burst_pulses;
                    if (burst_end)
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // result fields
    always_comb
    begin
        result_next.ir_level   = ((phase_next == PH_LEAD_BURST) ||
                                  (phase_next == PH_BIT_BURST) ||
                                  (phase_next == PH_STOP_BURST)) &&
                                 (carrier_next == CS_LOW1);
        result_next.busy_res   = (phase_next != PH_IDLE);
        result_next.accepted   = acc;
        result_next.frame_done = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leader_pulse_reg <= LEADER_PULSE_RESET;
            bit_pulse_reg    <= BIT_PULSE_RESET;
            leader_space_reg <= LEADER_SPACE_RESET;
            one_space_reg    <= ONE_SPACE_RESET;
            zero_space_reg   <= ZERO_SPACE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_LEADER_PULSE_COUNT: leader_pulse_reg <= cfg_data[9:0];
                REG_BIT_PULSE_COUNT:    bit_pulse_reg    <= cfg_data[9:0];
                REG_LEADER_SPACE_TICKS: leader_space_reg <= cfg_data;
                REG_ONE_SPACE_TICKS:    one_space_reg    <= cfg_data;
                REG_ZERO_SPACE_TICKS:   zero_space_reg   <= cfg_data;
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            carrier_reg <= CS_IDLE;
            pulses_reg  <= 10'd0;
            space_reg   <= 16'd0;
            frame_reg   <= '0;
            bits_reg    <= '0;
        end
        else if (item_fire)
        begin
            phase_reg   <= phase_next;
            carrier_reg <= carrier_next;
            pulses_reg  <= pulses_next;
            space_reg   <= space_next;
            frame_reg   <= frame_next;
            bits_reg    <= bits_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (item_fire)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            result_reg <= result_next;
        end
    end

endmodule

FILE: tb/nec_ir_frame_transmitter_top_test.sv
`timescale 1ns / 1ps

module nec_ir_frame_transmitter_top_test;
    import nectx_pkg::*;

    localparam int FRAME_LEN = 32;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 60;
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_START = 1'b1;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    class nec_frame_predictor;
        logic [9:0]    leader_pulses;
        logic [9:0]    bit_pulses;
        logic [15:0]   leader_space;
        logic [15:0]   one_space;
        logic [15:0]   zero_space;
        phase_t        tx_phase;
        carrier_step_t step;
        logic [9:0]    pulses_left;
        logic [15:0]   space_left;
        logic [31:0]   frame_bits;
        logic [5:0]    bits_sent;
        int            frame_len;
        result_t       pending_results[$];
        int            errors = 0;
        int            items_seen = 0;
        int            results_seen = 0;
        int            frames_sent = 0;
        int            starts_taken = 0;
        int            starts_refused = 0;
        int            reg_writes = 0;

        function new(int nbits);
            frame_len = nbits;
            leader_pulses = LEADER_PULSE_RESET;
            bit_pulses = BIT_PULSE_RESET;
            leader_space = LEADER_SPACE_RESET;
            one_space = ONE_SPACE_RESET;
            zero_space = ZERO_SPACE_RESET;
            tx_phase = PH_IDLE;
            step = CS_IDLE;
            pulses_left = '0;
            space_left = '0;
            frame_bits = '0;
            bits_sent = '0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            reg_writes++;
            case (idx)
                REG_LEADER_PULSE_COUNT: leader_pulses = data[9:0];
                REG_BIT_PULSE_COUNT:    bit_pulses = data[9:0];
                REG_LEADER_SPACE_TICKS: leader_space = data;
                REG_ONE_SPACE_TICKS:    one_space = data;
                REG_ZERO_SPACE_TICKS:   zero_space = data;
                default: ;
            endcase
        endfunction

        function bit frame_active();
            return tx_phase != PH_IDLE;
        endfunction

        function void start_burst(phase_t next, logic [9:0] count);
            tx_phase = next;
            step = CS_IDLE;
            pulses_left = count;
        endfunction

        // one carrier sub-phase, true when the burst is over
        function bit burst_step();
            case (step)
                CS_IDLE:
                begin
                    step = CS_HIGH;
                    return 1'b0;
                end
                CS_HIGH:
                begin
                    if (pulses_left != 0)
                        pulses_left--;
                    step = CS_LOW1;
                    return 1'b0;
                end
                CS_LOW1:
                begin
                    step = CS_LOW2;
                    return 1'b0;
                end
                default:
                begin
                    if (pulses_left != 0)
                    begin
                        step = CS_HIGH;
                        return 1'b0;
                    end
                    step = CS_IDLE;
                    return 1'b1;
                end
            endcase
        endfunction

        function bit space_step();
            if (space_left <= 1)
            begin
                space_left = '0;
                return 1'b1;
            end
            space_left--;
            return 1'b0;
        endfunction

        function void take_item(item_t x);
            result_t r;
            r = '0;
            items_seen++;
            if (x.cmd == CMD_START)
            begin
                if (tx_phase == PH_IDLE)
                begin
                    frame_bits = {~x.command, x.command, ~x.address, x.address};
                    bits_sent = '0;
                    space_left = '0;
                    start_burst(PH_LEAD_BURST, leader_pulses);
                    r.accepted = 1'b1;
                    starts_taken++;
                end
                else
                    starts_refused++;
            end
            else
            begin
                case (tx_phase)
                    PH_LEAD_BURST:
                        if (burst_step())
                        begin
                            tx_phase = PH_LEAD_SPACE;
                            space_left = leader_space;
                        end
                    PH_LEAD_SPACE:
                        if (space_step())
                            start_burst(PH_BIT_BURST, bit_pulses);
                    PH_BIT_BURST:
                        if (burst_step())
                        begin
                            tx_phase = PH_BIT_SPACE;
                            space_left = frame_bits[0] ? one_space : zero_space;
                        end
                    PH_BIT_SPACE:
                        if (space_step())
                        begin
                            frame_bits = frame_bits >> 1;
                            bits_sent = bits_sent + 6'd1;
                            if (bits_sent >= frame_len)
                                start_burst(PH_STOP_BURST, bit_pulses);
                            else
                                start_burst(PH_BIT_BURST, bit_pulses);
                        end
                    PH_STOP_BURST:
                        if (burst_step())
                        begin
                            tx_phase = PH_IDLE;
                            r.frame_done = 1'b1;
                            frames_sent++;
                        end
                    default: tx_phase = PH_IDLE;
                endcase
            end
            // level follows the sub-phase just finished
            r.ir_level = (tx_phase == PH_LEAD_BURST || tx_phase == PH_BIT_BURST ||
                          tx_phase == PH_STOP_BURST) && step == CS_LOW1;
            r.busy_res = tx_phase != PH_IDLE;
            pending_results.push_back(r);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task match_result(result_t got);
            result_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing expected", results_seen));
                return;
            end
            want = pending_results.pop_front();
            if (got.ir_level !== want.ir_level)
                report($sformatf("result %0d ir_level %b, expected %b",
                                 results_seen, got.ir_level, want.ir_level));
            if (got.busy_res !== want.busy_res)
                report($sformatf("result %0d busy_res %b, expected %b",
                                 results_seen, got.busy_res, want.busy_res));
            if (got.accepted !== want.accepted)
                report($sformatf("result %0d accepted %b, expected %b",
                                 results_seen, got.accepted, want.accepted));
            if (got.frame_done !== want.frame_done)
                report($sformatf("result %0d frame_done %b, expected %b",
                                 results_seen, got.frame_done, want.frame_done));
        endtask

        task close_out();
            if (pending_results.size() != 0)
                report($sformatf("%0d expected results never arrived", pending_results.size()));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    item_t       item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    nec_frame_predictor sb;
    int send_idle_pct = 15;
    int recv_idle_pct = 46;
    int idle_cycles = 0;
    int hold_left = 0;
    bit hold_request = 1'b0;

    nec_ir_frame_transmitter_top #(.FRAME_BITS(FRAME_LEN)) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                sb.match_result(result);
            if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_item(input item_t x);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= x;
        do
            @(posedge clk);
        while (item_stall);
        sb.take_item(x);
    endtask

    task automatic send_tick();
        send_item('{CMD_TICK, 8'($urandom), 8'($urandom)});
    endtask

    task automatic send_start(input logic [7:0] addr, input logic [7:0] code);
        send_item('{CMD_START, addr, code});
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            if (!sb.frame_active() && $urandom_range(0, 99) < 60)
                send_start(8'($urandom), 8'($urandom));
            else if (sb.frame_active() && $urandom_range(0, 99) < 3)
                send_start(8'($urandom), 8'($urandom));
            else
                send_tick();
        end
    endtask

    task automatic finish_frame();
        while (sb.frame_active())
            send_tick();
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] lead, input logic [15:0] bursts,
                              input logic [15:0] lead_gap, input logic [15:0] one_gap,
                              input logic [15:0] zero_gap);
        wait_drained();
        repeat (4) @(posedge clk);
        write_reg(REG_LEADER_PULSE_COUNT, lead);
        write_reg(REG_BIT_PULSE_COUNT, bursts);
        write_reg(REG_LEADER_SPACE_TICKS, lead_gap);
        write_reg(REG_ONE_SPACE_TICKS, one_gap);
        write_reg(REG_ZERO_SPACE_TICKS, zero_gap);
    endtask

    // upper bits of the pulse counts are junk that the block drops
    task automatic random_config();
        logic [15:0] lead;
        logic [15:0] bursts;
        lead = {6'($urandom), 10'($urandom_range(0, 3))};
        bursts = {6'($urandom), 10'($urandom_range(0, 2))};
        set_config(lead, bursts, 16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)),
                   16'($urandom_range(0, 4)));
    endtask

    initial
    begin
        sb = new(FRAME_LEN);
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_config(16'd1, 16'd1, 16'd1, 16'd3, 16'd1);
        send_tick();
        send_item('{CMD_TICK, 8'hFF, 8'hFF});
        send_start(8'h00, 8'hFF);
        send_start(8'hFF, 8'h00);
        repeat (12) send_tick();
        send_start(8'h5A, 8'hA5);
        finish_frame();

        set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        write_reg(REG_UNUSED, 16'hFFFF);
        send_start(8'hFF, 8'h00);
        repeat (6) send_tick();
        send_start(8'h00, 8'h00);
        finish_frame();

        random_config();
        run_random(60);
        hold_request = 1'b1;
        run_random(30);
        wait_drained();
        run_random(10);

        send_idle_pct = 46;
        recv_idle_pct = 15;
        random_config();
        run_random(70);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_config();
        run_random(70);

        // widest counts and spaces, loaded as their bursts and spaces begin
        set_config(16'd1023, 16'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_start(8'($urandom), 8'($urandom));
        repeat (30) send_tick();

        wait_drained();
        repeat (10) @(posedge clk);
        sb.close_out();
        $display("%0d transactions sent: %0d frame starts taken, %0d refused, %0d frames finished",
                 sb.items_seen, sb.starts_taken, sb.starts_refused, sb.frames_sent);
        $display("%0d results checked over %0d register writes, stalls on both channels",
                 sb.results_seen, sb.reg_writes);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: nec_ir_frame_transmitter_top.f
rtl/nectx_pkg.sv
rtl/nec_ir_frame_transmitter_top.sv
tb/nec_ir_frame_transmitter_top_test.sv
